/* rtl/core/serial_mouse_delta_filter_core_macros.svh */
// assertion helpers used by the checker of this block
`ifndef SERIAL_MOUSE_DELTA_FILTER_CORE_MACROS_SVH
`define SERIAL_MOUSE_DELTA_FILTER_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define SMDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet while reset is low
`define SMDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/smdf_pkg.sv */
package smdf_pkg;

  localparam int DeltaW  = 8;
  localparam int ButtonW = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 8;

  // action codes
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegJitterRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSpeedLawOn   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpeedLimit   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHoldTicks    = 2'd3;

  localparam logic [3:0]         ButtonNibble = 4'h8;
  localparam logic [6:0]         JitterReset  = 7'd1;
  localparam logic [6:0]         LimitReset   = 7'd48;
  localparam logic [7:0]         HoldReset    = 8'd5;
  localparam logic [ButtonW-1:0] LastBtnReset = 3'd7;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta_x;
    logic signed [DeltaW-1:0] delta_y;
    logic [ButtonW-1:0]       button_bits;
    logic                     speed_exceeded;
    logic                     from_timeout;
  } smdf_res_t;

  typedef struct packed {
    smdf_res_t   res;
    logic [DeltaW-1:0] carry_x;
    logic [DeltaW-1:0] carry_y;
  } smdf_commit_t;

  // x2 for double-resolution mice
  function automatic logic [7:0] scale_lim(input logic [6:0] v, input logic dres);
    return dres ? {v, 1'b0} : {1'b0, v};
  endfunction

  function automatic logic beyond(input logic [DeltaW-1:0] v, input logic [7:0] lim);
    logic signed [9:0] vs;
    logic signed [9:0] ls;
    vs = {{2{v[DeltaW-1]}}, v};
    ls = signed'({2'b00, lim});
    return (vs > ls) || (vs < -ls);
  endfunction

  function automatic smdf_commit_t do_commit(
    input logic [DeltaW-1:0]  ax,
    input logic [DeltaW-1:0]  ay,
    input logic               dres,
    input logic               law_on,
    input logic [6:0]         limit,
    input logic [ButtonW-1:0] buttons,
    input logic               timed
  );
    smdf_commit_t c;
    logic [7:0]        lim;
    logic              fx;
    logic              fy;
    logic [DeltaW-1:0] x;
    logic [DeltaW-1:0] y;
    lim = scale_lim(limit, dres);
    fx  = law_on && beyond(ax, lim);
    fy  = law_on && beyond(ay, lim);
    x   = fx ? '0 : ax;
    y   = fy ? '0 : ay;
    c.carry_x = '0;
    c.carry_y = '0;
    if (dres) begin
      // keep the odd bit for the next sample, halve with floor
      c.carry_x = {{(DeltaW-1){1'b0}}, x[0]};
      c.carry_y = {{(DeltaW-1){1'b0}}, y[0]};
      x = {x[DeltaW-1], x[DeltaW-1:1]};
      y = {y[DeltaW-1], y[DeltaW-1:1]};
    end
    c.res.delta_x        = signed'(x);
    c.res.delta_y        = signed'(y);
    c.res.button_bits    = buttons;
    c.res.speed_exceeded = fx || fy;
    c.res.from_timeout   = timed;
    return c;
  endfunction

endpackage

/* rtl/core/serial_mouse_delta_filter_core.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | in_action, in_rx_byte
// out     | output    | out_valid / out_stall  | deltas, buttons, flags
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one byte or tick is taken per cycle while in_stall is low; its sample is registered
// in the output register, which a one-entry skid stage backs up
// in_stall rises only when both output register and skid stage hold samples
// cfg_ready is always high; reset (rst_n low, synchronous) clears all state but the output and skid payloads
module serial_mouse_delta_filter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [7:0]            out_delta_x,
  output logic signed [7:0]            out_delta_y,
  output logic [2:0]                   out_button_bits,
  output logic                         out_speed_exceeded,
  output logic                         out_from_timeout,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [smdf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [smdf_pkg::CfgDatW-1:0] cfg_data
);
  import smdf_pkg::*;

  logic [6:0]         jitter_r;
  logic               law_on_r;
  logic [6:0]         limit_r;
  logic [7:0]         hold_ticks_r;

  logic [DeltaW-1:0]  acc_x_r, acc_x_nxt;
  logic [DeltaW-1:0]  acc_y_r, acc_y_nxt;
  logic [ButtonW-1:0] cur_btn_r, cur_btn_nxt;
  logic [ButtonW-1:0] last_btn_r, last_btn_nxt;
  logic               dres_r, dres_nxt;
  logic               expect_x_r, expect_x_nxt;
  logic               hold_r, hold_nxt;
  logic [7:0]         hold_cnt_r, hold_cnt_nxt;

  logic               out_valid_r, skid_valid_r;
  smdf_res_t          out_r, skid_r;

  logic               accept;
  logic               res_valid;
  smdf_res_t          res;
  smdf_commit_t       cm;
  logic [DeltaW-1:0]  new_y;
  logic [7:0]         radius;
  logic               commit_en;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_r     <= JitterReset;
      law_on_r     <= 1'b1;
      limit_r      <= LimitReset;
      hold_ticks_r <= HoldReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegJitterRadius: jitter_r     <= cfg_data[6:0];
        RegSpeedLawOn:   law_on_r     <= cfg_data[0];
        RegSpeedLimit:   limit_r      <= cfg_data[6:0];
        RegHoldTicks:    hold_ticks_r <= cfg_data;
      endcase
    end
  end

  assign new_y  = acc_y_r - in_rx_byte;
  assign radius = scale_lim(jitter_r, dres_r);
  // a tick commits the held accumulators; a y byte commits the updated y
  assign cm     = do_commit(acc_x_r, (in_action == ActTick) ? acc_y_r : new_y,
                            dres_r, law_on_r, limit_r, cur_btn_r, in_action == ActTick);

  always_comb begin
    acc_x_nxt    = acc_x_r;
    acc_y_nxt    = acc_y_r;
    cur_btn_nxt  = cur_btn_r;
    last_btn_nxt = last_btn_r;
    dres_nxt     = dres_r;
    expect_x_nxt = expect_x_r;
    hold_nxt     = hold_r;
    hold_cnt_nxt = hold_cnt_r;
    commit_en    = 1'b0;
    if (in_action == ActTick) begin
      if (hold_r) begin
        if (hold_cnt_r <= 8'd1) begin
          hold_nxt     = 1'b0;
          hold_cnt_nxt = '0;
          commit_en    = 1'b1;
        end else begin
          hold_cnt_nxt = hold_cnt_r - 8'd1;
        end
      end
    end else if (in_rx_byte[7:4] == ButtonNibble) begin
      cur_btn_nxt  = in_rx_byte[2:0];
      dres_nxt     = in_rx_byte[3];
      expect_x_nxt = 1'b1;
    end else if (expect_x_r) begin
      acc_x_nxt    = acc_x_r + in_rx_byte;
      expect_x_nxt = 1'b0;
    end else begin
      acc_y_nxt    = new_y;
      expect_x_nxt = 1'b1;
      hold_nxt     = 1'b0;
      hold_cnt_nxt = '0;
      commit_en    = 1'b1;
      if (cur_btn_r == last_btn_r) begin
        if (acc_x_r == '0 && new_y == '0) begin
          commit_en = 1'b0;
        end else if (!beyond(acc_x_r, radius) && !beyond(new_y, radius)) begin
          // small motion waits for more bytes or for the tick countdown
          commit_en    = 1'b0;
          hold_nxt     = 1'b1;
          hold_cnt_nxt = hold_ticks_r;
        end
      end
      if (commit_en) begin
        last_btn_nxt = cur_btn_r;
      end
    end
    if (commit_en) begin
      acc_x_nxt = cm.carry_x;
      acc_y_nxt = cm.carry_y;
    end
  end

  assign res_valid = accept && commit_en;
  assign res       = cm.res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      cur_btn_r  <= '0;
      last_btn_r <= LastBtnReset;
      dres_r     <= 1'b0;
      expect_x_r <= 1'b1;
      hold_r     <= 1'b0;
      hold_cnt_r <= '0;
    end else if (accept) begin
      acc_x_r    <= acc_x_nxt;
      acc_y_r    <= acc_y_nxt;
      cur_btn_r  <= cur_btn_nxt;
      last_btn_r <= last_btn_nxt;
      dres_r     <= dres_nxt;
      expect_x_r <= expect_x_nxt;
      hold_r     <= hold_nxt;
      hold_cnt_r <= hold_cnt_nxt;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_delta_x        = out_r.delta_x;
  assign out_delta_y        = out_r.delta_y;
  assign out_button_bits    = out_r.button_bits;
  assign out_speed_exceeded = out_r.speed_exceeded;
  assign out_from_timeout   = out_r.from_timeout;

endmodule

/* rtl/core/smdf_checker.sv */
`include "serial_mouse_delta_filter_core_macros.svh"

module smdf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] out_delta_x,
  input logic signed [7:0] out_delta_y,
  input logic [2:0]        out_button_bits,
  input logic              out_speed_exceeded,
  input logic              out_from_timeout
);

  logic [20:0] out_payload;
  logic        any_zero;

  assign out_payload = {out_delta_x, out_delta_y, out_button_bits,
                        out_speed_exceeded, out_from_timeout};
  assign any_zero    = (out_delta_x == 8'sd0) || (out_delta_y == 8'sd0);

  // stalled request holds
  `SMDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // input backpressure only with a full output register behind it
  `SMDF_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, out_valid)

  // input stall begins only after a stalled output cycle
  `SMDF_ASSERT_IMPL(a_stall_rise, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))

  // a fast sample has at least one axis zeroed
  `SMDF_ASSERT_IMPL(a_fast_zero, clk, rst_n, out_valid && out_speed_exceeded, any_zero)

endmodule

bind serial_mouse_delta_filter_core smdf_checker u_smdf_checker (.*);

/* test/tb_serial_mouse_delta_filter_core.sv */
`default_nettype none

module tb_serial_mouse_delta_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import smdf_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = 4;
  localparam int PhaseItems  = 105;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = ActByte;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [7:0]   out_delta_x;
  logic signed [7:0]   out_delta_y;
  logic [2:0]          out_button_bits;
  logic                out_speed_exceeded;
  logic                out_from_timeout;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = RegJitterRadius;
  logic [CfgDatW-1:0]  cfg_data = '0;

  // filter settings as the decoder sees them
  logic [6:0] jit_r;
  logic       law_on;
  logic [6:0] speed_lim;
  logic [7:0] hold_len;

  // decoder state
  logic [7:0] acc_x;
  logic [7:0] acc_y;
  logic [2:0] cur_btn;
  logic [2:0] last_btn;
  logic       dres;
  logic       want_x;
  logic       held;
  logic [7:0] hold_cnt;

  smdf_res_t expected_samples [$];

  bit gaps_on = 1'b1;
  int errors = 0;
  int items_sent = 0;
  int samples_seen = 0;
  int timeout_samples = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  serial_mouse_delta_filter_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_delta_x        (out_delta_x),
    .out_delta_y        (out_delta_y),
    .out_button_bits    (out_button_bits),
    .out_speed_exceeded (out_speed_exceeded),
    .out_from_timeout   (out_from_timeout),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic smdf_res_t commit_sample(logic timed);
    smdf_res_t  r;
    int         x;
    int         y;
    int         lim;
    logic       fx;
    logic       fy;
    logic [7:0] cx;
    logic [7:0] cy;
    x = int'($signed(acc_x));
    y = int'($signed(acc_y));
    lim = int'(speed_lim) * (dres ? 2 : 1);
    fx = 1'b0;
    fy = 1'b0;
    if (law_on) begin
      fx = (x > lim) || (x < -lim);
      fy = (y > lim) || (y < -lim);
      if (fx) x = 0;
      if (fy) y = 0;
    end
    cx = 8'd0;
    cy = 8'd0;
    if (dres) begin
      // odd bit rides over into the next sample
      cx = {7'd0, x[0]};
      cy = {7'd0, y[0]};
      x = x >>> 1;
      y = y >>> 1;
    end
    r.delta_x        = x[7:0];
    r.delta_y        = y[7:0];
    r.button_bits    = cur_btn;
    r.speed_exceeded = fx | fy;
    r.from_timeout   = timed;
    acc_x = cx;
    acc_y = cy;
    return r;
  endfunction

  task automatic mouse_decode(logic act, logic [7:0] b);
    int x;
    int y;
    int r;
    if (act == ActTick) begin
      if (held) begin
        if (hold_cnt <= 8'd1) begin
          held = 1'b0;
          hold_cnt = 8'd0;
          expected_samples.push_back(commit_sample(1'b1));
        end else begin
          hold_cnt = hold_cnt - 8'd1;
        end
      end
    end else if (b[7:4] == ButtonNibble) begin
      cur_btn = b[2:0];
      dres = b[3];
      want_x = 1'b1;
    end else if (want_x) begin
      acc_x = acc_x + b;
      want_x = 1'b0;
    end else begin
      acc_y = acc_y - b;
      want_x = 1'b1;
      held = 1'b0;
      hold_cnt = 8'd0;
      x = int'($signed(acc_x));
      y = int'($signed(acc_y));
      r = int'(jit_r) * (dres ? 2 : 1);
      if (cur_btn != last_btn || !(x <= r && x >= -r && y <= r && y >= -r)) begin
        last_btn = cur_btn;
        expected_samples.push_back(commit_sample(1'b0));
      end else if (x != 0 || y != 0) begin
        held = 1'b1;
        hold_cnt = hold_len;
      end
    end
  endtask

  task automatic reset_decoder();
    jit_r = JitterReset;
    law_on = 1'b1;
    speed_lim = LimitReset;
    hold_len = HoldReset;
    acc_x = 8'd0;
    acc_y = 8'd0;
    cur_btn = 3'd0;
    last_btn = LastBtnReset;
    dres = 1'b0;
    want_x = 1'b1;
    held = 1'b0;
    hold_cnt = 8'd0;
  endtask

  task automatic note_mismatch(string what, smdf_res_t want, smdf_res_t got);
    errors++;
    if (errors <= MaxReports) begin
      $display("mismatch (%s): exp dx=%0d dy=%0d btn=%0d fast=%0b tmo=%0b",
               what, want.delta_x, want.delta_y, want.button_bits,
               want.speed_exceeded, want.from_timeout);
      $display("  got dx=%0d dy=%0d btn=%0d fast=%0b tmo=%0b",
               got.delta_x, got.delta_y, got.button_bits,
               got.speed_exceeded, got.from_timeout);
    end
  endtask

  always @(posedge clk) begin
    smdf_res_t want;
    smdf_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.delta_x        = out_delta_x;
      got.delta_y        = out_delta_y;
      got.button_bits    = out_button_bits;
      got.speed_exceeded = out_speed_exceeded;
      got.from_timeout   = out_from_timeout;
      samples_seen++;
      if (got.from_timeout) timeout_samples++;
      if (expected_samples.size() == 0) begin
        want = '0;
        note_mismatch("no sample expected", want, got);
      end else begin
        want = expected_samples.pop_front();
        if (got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
            got.button_bits !== want.button_bits ||
            got.speed_exceeded !== want.speed_exceeded ||
            got.from_timeout !== want.from_timeout)
          note_mismatch("field", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no request moved for %0d cycles, %0d samples pending",
               IdleLimit, expected_samples.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output back-pressure in random bursts
  initial begin
    forever begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(40, 100)) @(posedge clk);
      else
        repeat ($urandom_range(1, 20)) @(posedge clk);
      if (gaps_on && $urandom_range(0, 1) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic act, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    mouse_decode(act, b);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      RegJitterRadius: jit_r = value[6:0];
      RegSpeedLawOn:   law_on = value[0];
      RegSpeedLimit:   speed_lim = value[6:0];
      RegHoldTicks:    hold_len = value;
      default: ;
    endcase
  endtask

  task automatic set_filter(logic [6:0] jr, logic law, logic [6:0] sl, logic [7:0] ht);
    pause_until_drained();
    // a dropped or held sample may still be in flight
    repeat (DrainCycles) @(posedge clk);
    cfg_write(RegJitterRadius, {1'b0, jr});
    cfg_write(RegSpeedLawOn, {7'd0, law});
    cfg_write(RegSpeedLimit, {1'b0, sl});
    cfg_write(RegHoldTicks, ht);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] rand_delta();
    int         k;
    int         v;
    int         sel;
    logic [7:0] b;
    k = int'(jit_r) * (dres ? 2 : 1) + 1;
    if (k > 112) k = 112;
    sel = $urandom_range(0, 9);
    if (sel == 9) return 8'($urandom);
    if (sel < 6) v = int'($urandom_range(0, 2 * k)) - k;
    else v = int'($urandom_range(0, 255)) - 128;
    b = v[7:0];
    // keep deltas from being read as a button byte
    if (b[7:4] == ButtonNibble) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [7:0] rand_button_byte();
    logic [2:0] btn;
    btn = ($urandom_range(0, 3) == 0) ? 3'($urandom) : last_btn;
    return {ButtonNibble, 1'($urandom), btn};
  endfunction

  task automatic send_ticks();
    int n;
    if ($urandom_range(0, 7) == 0 && hold_len <= 8'd16)
      n = int'(hold_len) + 1;
    else
      n = $urandom_range(0, 3);
    repeat (n) send_item(ActTick, 8'($urandom));
  endtask

  task automatic test_directed_defaults();
    send_item(ActTick, 8'hFF);          // nothing held, tick ignored
    send_item(ActByte, 8'h80);
    send_item(ActByte, 8'h05);
    send_item(ActByte, 8'h03);          // buttons changed from reset value
    send_item(ActByte, 8'h80);
    send_item(ActByte, 8'h00);
    send_item(ActByte, 8'h00);          // no change, dropped
    send_item(ActByte, 8'h01);
    send_item(ActByte, 8'hFF);          // jitter, held
    repeat (5) send_item(ActTick, 8'hA5);
    send_item(ActByte, 8'h01);
    send_item(ActByte, 8'h00);          // held again
    send_item(ActByte, 8'h7F);
    send_item(ActByte, 8'h00);          // hold cancelled, x wraps to -128, over limit
    send_item(ActByte, 8'h8F);
    send_item(ActByte, 8'h31);
    send_item(ActByte, 8'hCF);          // double resolution, halved with carry
    send_item(ActByte, 8'h8F);
    send_item(ActByte, 8'h7F);
    send_item(ActByte, 8'h70);          // both axes over doubled limit
    send_item(ActByte, 8'h84);
    send_item(ActByte, 8'h02);
    send_item(ActByte, 8'h82);          // broken packet restarts on button byte
    send_item(ActByte, 8'h7E);
    send_item(ActByte, 8'h90);
  endtask

  task automatic test_hold_zero_law_off();
    set_filter(7'd2, 1'b0, 7'd0, 8'd0);
    send_item(ActByte, 8'h83);
    send_item(ActByte, 8'h7F);
    send_item(ActByte, 8'h81);          // law off, big motion passes
    send_item(ActByte, 8'h01);
    send_item(ActByte, 8'h00);          // held with zero hold length
    send_item(ActTick, 8'h3C);
    send_item(ActByte, 8'h02);
    send_item(ActByte, 8'hFE);
    send_item(ActByte, 8'h01);
    send_item(ActByte, 8'h00);          // new x grows past radius
    send_item(ActByte, 8'h8B);
    send_item(ActByte, 8'h81);
    send_item(ActByte, 8'h7F);
  endtask

  task automatic test_long_hold();
    set_filter(7'd127, 1'b1, 7'd127, 8'd255);
    send_item(ActByte, 8'h83);
    send_item(ActByte, 8'h40);
    send_item(ActByte, 8'h30);
    send_item(ActByte, 8'h10);
    send_item(ActByte, 8'hF0);          // same buttons, inside wide radius
    repeat (256) send_item(ActTick, 8'($urandom));
  endtask

  task automatic run_random_phase(int n_items);
    int first;
    int kind;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if ($urandom_range(0, 4) != 0) send_item(ActByte, rand_button_byte());
        send_item(ActByte, rand_delta());
        send_item(ActByte, rand_delta());
        send_ticks();
      end else if (kind < 85) begin
        send_item(ActByte, rand_button_byte());
        if ($urandom_range(0, 1) == 1) send_item(ActByte, rand_delta());
        send_item(ActByte, rand_button_byte());
      end else begin
        repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 59) == 0) pause_until_drained();
    end
  endtask

  task automatic test_random_settings();
    set_filter(JitterReset, 1'b1, LimitReset, HoldReset);
    run_random_phase(PhaseItems);
    set_filter(7'd0, 1'b0, 7'd0, 8'd1);
    run_random_phase(PhaseItems);
    set_filter(7'd127, 1'b1, 7'd127, 8'd255);
    run_random_phase(PhaseItems);
    set_filter(7'd3, 1'b1, 7'd10, 8'd3);
    run_random_phase(PhaseItems);
    set_filter(7'd12, 1'b1, 7'd4, 8'd2);
    run_random_phase(PhaseItems);
    set_filter(7'($urandom_range(0, 15)), 1'($urandom), 7'($urandom_range(0, 127)),
               8'($urandom_range(1, 8)));
    run_random_phase(PhaseItems);
  endtask

  task automatic test_back_to_back();
    set_filter(7'($urandom_range(0, 15)), 1'($urandom), 7'($urandom_range(0, 127)),
               8'($urandom_range(1, 8)));
    gaps_on = 1'b0;
    run_random_phase(PhaseItems);
  endtask

  initial begin
    reset_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_defaults();
    test_hold_zero_law_off();
    test_long_hold();
    test_random_settings();
    test_back_to_back();
    pause_until_drained();
    repeat (20) @(posedge clk);
    if (expected_samples.size() != 0) begin
      errors++;
      $display("%0d expected samples never arrived", expected_samples.size());
    end
    $display("sent %0d bytes and ticks under %0d filter settings", items_sent, settings_used);
    $display("checked %0d samples, %0d released by hold expiry, %0d errors",
             samples_seen, timeout_samples, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* serial_mouse_delta_filter_core.f */
+incdir+rtl/core
rtl/core/smdf_pkg.sv
rtl/core/serial_mouse_delta_filter_core.sv
rtl/core/smdf_checker.sv
test/tb_serial_mouse_delta_filter_core.sv
